>>> hdl/otpjs_pkg.sv
package otpjs_pkg;

    localparam logic [2:0] OP_SUBMIT   = 3'd0;
    localparam logic [2:0] OP_DISPATCH = 3'd1;
    localparam logic [2:0] OP_COMPLETE = 3'd2;
    localparam logic [2:0] OP_CANCEL   = 3'd3;
    localparam logic [2:0] OP_QUERY    = 3'd4;
    localparam logic [2:0] OP_SHUTDOWN = 3'd5;
    localparam logic [2:0] OP_START    = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_REFUSED   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_RUN   = 3'd4;

    localparam logic CFG_WORKER_COUNT = 1'b0;
    localparam logic CFG_CLOSE        = 1'b1;

    localparam int CFG_DATA_BITS = 7;
    localparam int COUNT_BITS    = 7;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  owner;
        logic [7:0]  priority_req;
        logic [15:0] job_tag;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_job_tag;
        logic [7:0]  out_owner;
        logic [7:0]  out_priority;
        logic [4:0]  entry_count;
        logic [6:0]  owner_running;
        logic        owner_idle;
        logic        pool_idle;
        logic [6:0]  busy_count;
    } rsp_t;

endpackage

>>> hdl/owner_tagged_priority_job_scheduler_top.sv
// owner-tagged priority job scheduler
// s_ channel: one request transaction (submit, dispatch, complete, cancel,
// query, shutdown, start); m_ channel: exactly one response per request.
// cfg_wr_en/cfg_index/cfg_wdata write worker_count (0) and close_on_shutdown (1);
// the user writes them only while the block is idle, which the block does not enforce.
// one request at a time: s_ready is high only while the sequencer is idle,
// which starts in the cycle that the previous response turns valid.
// submit, shutdown, start and refused requests go straight to the response;
// complete reads and then writes the owner's running counter (S_CRD, S_CWR);
// cancel and query scan the queue, one queue entry read per cycle, and query
// then also reads the owner's running counter;
// dispatch scans for the best entry, then shifts the younger entries down one
// place through the same ram port and updates the owner's running counter.
// after reset the per-owner running counters are cleared one per cycle, all
// 2**OWNER_BITS of them, before the first request is taken.
// reset empties the queue, zeroes the busy count, and leaves the pool inactive.
// a stalled m_ready holds the response; the next request may be taken meanwhile,
// and its response waits until the held one has been accepted.
module owner_tagged_priority_job_scheduler_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_WORKERS = 64,
    parameter int OWNER_BITS  = 8,
    parameter int TAG_BITS    = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic                                   cfg_index,
    input  logic [otpjs_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  otpjs_pkg::req_t                        s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output otpjs_pkg::rsp_t                        m_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int CB = otpjs_pkg::COUNT_BITS;
    localparam int QW = OWNER_BITS + 8 + TAG_BITS;

    typedef struct packed {
        logic [OWNER_BITS-1:0] owner;
        logic [7:0]            prio;
        logic [TAG_BITS-1:0]   tag;
    } entry_t;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_MOVE  = 7'b0001000,
        S_CRD   = 7'b0010000,
        S_CWR   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    otpjs_pkg::req_t      req_reg, req_next;
    otpjs_pkg::rsp_t      res_reg, res_next;
    otpjs_pkg::rsp_t      out_reg, out_next;
    logic                 m_valid_reg, m_valid_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [LW-1:0]        ptr_reg, ptr_next;
    logic [LW-1:0]        wp_reg, wp_next;
    logic [LW-1:0]        cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        best_idx_reg, best_idx_next;
    entry_t               best_reg, best_next;
    logic [CB-1:0]        busy_reg, busy_next;
    logic                 active_reg, active_next;
    logic                 closed_reg, closed_next;
    logic [CB-1:0]        wc_reg, wc_next;
    logic                 cos_reg, cos_next;
    logic [OWNER_BITS:0]  clr_reg, clr_next;

    logic                  q_we;
    logic [AW-1:0]         q_waddr;
    entry_t                q_wdata;
    logic [QW-1:0]         q_rdata;
    entry_t                q_rd;
    logic                  c_we;
    logic [OWNER_BITS-1:0] c_waddr;
    logic [CB-1:0]         c_wdata;
    logic [CB-1:0]         c_rd;
    logic [OWNER_BITS-1:0] req_owner;
    logic [OWNER_BITS-1:0] cur_owner;
    logic [CB-1:0]         limit;
    logic                  more;

    assign q_rd      = entry_t'(q_rdata);
    assign req_owner = OWNER_BITS'(req_reg.owner);
    assign cur_owner = (req_reg.operation == otpjs_pkg::OP_DISPATCH) ? best_reg.owner
                                                                      : req_owner;
    assign limit     = (wc_reg > CB'(MAX_WORKERS)) ? CB'(MAX_WORKERS) : wc_reg;
    assign more      = (ptr_reg < len_reg);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    otpjs_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk    (aclk),
        .wr_en   (q_we),
        .wr_addr (q_waddr),
        .wr_data (q_wdata),
        .rd_addr (ptr_reg[AW-1:0]),
        .rd_data (q_rdata)
    );

    otpjs_ram #(.WIDTH(CB), .DEPTH(2 ** OWNER_BITS)) u_counts (
        .aclk    (aclk),
        .wr_en   (c_we),
        .wr_addr (c_waddr),
        .wr_data (c_wdata),
        .rd_addr (cur_owner),
        .rd_data (c_rd)
    );

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;
        len_next      = len_reg;
        ptr_next      = ptr_reg;
        wp_next       = wp_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        busy_next     = busy_reg;
        active_next   = active_reg;
        closed_next   = closed_reg;
        wc_next       = wc_reg;
        cos_next      = cos_reg;
        clr_next      = clr_reg;
        q_we          = 1'b0;
        q_waddr       = len_reg[AW-1:0];
        q_wdata       = q_rd;
        c_we          = 1'b0;
        c_waddr       = cur_owner;
        c_wdata       = c_rd;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_index)
                otpjs_pkg::CFG_WORKER_COUNT: wc_next = cfg_wdata;
                otpjs_pkg::CFG_CLOSE:        cos_next = cfg_wdata[0];
                default: ;
            endcase
        end

        case (state_reg)
            S_CLEAR: begin
                c_we     = 1'b1;
                c_waddr  = clr_reg[OWNER_BITS-1:0];
                c_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg[OWNER_BITS-1:0] == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    res_next   = '0;
                    ptr_next   = '0;
                    wp_next    = '0;
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_FIN;
                    case (s_data.operation)
                        otpjs_pkg::OP_SUBMIT: begin
                            if (closed_reg) begin
                                res_next.status = otpjs_pkg::ST_REFUSED;
                            end else if (len_reg >= LW'(QUEUE_DEPTH)) begin
                                res_next.status = otpjs_pkg::ST_FULL;
                            end else begin
                                q_we          = 1'b1;
                                q_waddr       = len_reg[AW-1:0];
                                q_wdata.owner = OWNER_BITS'(s_data.owner);
                                q_wdata.prio  = s_data.priority_req;
                                q_wdata.tag   = TAG_BITS'(s_data.job_tag);
                                len_next      = len_reg + 1'b1;
                            end
                        end
                        otpjs_pkg::OP_DISPATCH: begin
                            if (!active_reg || busy_reg >= limit) begin
                                res_next.status = otpjs_pkg::ST_REFUSED;
                            end else if (len_reg == '0) begin
                                res_next.status = otpjs_pkg::ST_EMPTY;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        otpjs_pkg::OP_COMPLETE: state_next = S_CRD;
                        otpjs_pkg::OP_CANCEL:   state_next = S_SCAN;
                        otpjs_pkg::OP_QUERY:    state_next = S_SCAN;
                        otpjs_pkg::OP_SHUTDOWN: begin
                            len_next    = '0;
                            active_next = 1'b0;
                            if (cos_reg) begin
                                closed_next = 1'b1;
                            end
                        end
                        otpjs_pkg::OP_START: begin
                            if (!active_reg && wc_reg != '0) begin
                                active_next = 1'b1;
                                closed_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                pend_next = more;
                idx_next  = ptr_reg[AW-1:0];
                if (more) begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (pend_reg) begin
                    case (req_reg.operation)
                        otpjs_pkg::OP_DISPATCH: begin
                            if (idx_reg == '0 || q_rd.prio > best_reg.prio) begin
                                best_next     = q_rd;
                                best_idx_next = idx_reg;
                            end
                        end
                        otpjs_pkg::OP_CANCEL: begin
                            if (q_rd.owner == req_owner) begin
                                cnt_next = cnt_reg + 1'b1;
                            end else begin
                                q_we    = 1'b1;
                                q_waddr = wp_reg[AW-1:0];
                                q_wdata = q_rd;
                                wp_next = wp_reg + 1'b1;
                            end
                        end
                        default: begin
                            if (q_rd.owner == req_owner) begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                    endcase
                end else if (!more) begin
                    pend_next = 1'b0;
                    case (req_reg.operation)
                        otpjs_pkg::OP_DISPATCH: begin
                            ptr_next   = LW'(best_idx_reg) + 1'b1;
                            state_next = S_MOVE;
                        end
                        otpjs_pkg::OP_CANCEL: begin
                            len_next             = wp_reg;
                            res_next.entry_count = 5'(cnt_reg);
                            state_next           = S_FIN;
                        end
                        default: begin
                            res_next.entry_count = 5'(cnt_reg);
                            state_next           = S_CRD;
                        end
                    endcase
                end
            end
            S_MOVE: begin
                pend_next = more;
                idx_next  = ptr_reg[AW-1:0];
                if (more) begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (pend_reg) begin
                    q_we    = 1'b1;
                    q_waddr = idx_reg - AW'(1);
                    q_wdata = q_rd;
                end else if (!more) begin
                    len_next   = len_reg - 1'b1;
                    state_next = S_CRD;
                end
            end
            S_CRD: begin
                state_next = S_CWR;
            end
            S_CWR: begin
                state_next = S_FIN;
                case (req_reg.operation)
                    otpjs_pkg::OP_DISPATCH: begin
                        c_we                  = 1'b1;
                        c_wdata               = c_rd + 1'b1;
                        busy_next             = busy_reg + 1'b1;
                        res_next.out_job_tag  = 16'(best_reg.tag);
                        res_next.out_owner    = 8'(best_reg.owner);
                        res_next.out_priority = best_reg.prio;
                    end
                    otpjs_pkg::OP_COMPLETE: begin
                        if (c_rd == '0) begin
                            res_next.status = otpjs_pkg::ST_NOT_RUN;
                        end else begin
                            c_we    = 1'b1;
                            c_wdata = c_rd - 1'b1;
                            if (busy_reg != '0) begin
                                busy_next = busy_reg - 1'b1;
                            end
                        end
                    end
                    default: begin
                        res_next.owner_running = c_rd;
                        res_next.owner_idle    = (c_rd == '0) &&
                                                 (!active_reg || cnt_reg == '0);
                        res_next.pool_idle     = (busy_reg == '0) &&
                                                 (len_reg == '0 || !active_reg);
                        res_next.busy_count    = busy_reg;
                    end
                endcase
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    out_next     = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
            len_reg     <= '0;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            busy_reg    <= '0;
            active_reg  <= 1'b0;
            closed_reg  <= 1'b0;
            wc_reg      <= CB'(1);
            cos_reg     <= 1'b0;
            clr_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            len_reg     <= len_next;
            ptr_reg     <= ptr_next;
            pend_reg    <= pend_next;
            busy_reg    <= busy_next;
            active_reg  <= active_next;
            closed_reg  <= closed_next;
            wc_reg      <= wc_next;
            cos_reg     <= cos_next;
            clr_reg     <= clr_next;
        end
        req_reg      <= req_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        wp_reg       <= wp_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
    end

endmodule

>>> hdl/otpjs_ram.sv
module otpjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
